// File: hw/rtl/signature_hash_learn_monitor_set_assert.svh
// Assertion macros used by the signature hash set table engine.
`ifndef SIGNATURE_HASH_LEARN_MONITOR_SET_ASSERT_SVH
`define SIGNATURE_HASH_LEARN_MONITOR_SET_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SHLMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("signature hash set assertion failed");
// Check that a condition never occurs.
`define SHLMS_ASSERT_NEVER(lbl, expr) `SHLMS_ASSERT(lbl, !(expr))
`else
`define SHLMS_ASSERT(lbl, prop)
`define SHLMS_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: hw/rtl/shlms_pkg.sv
// Package with types, constants and the hash step of the signature hash set.
`timescale 1ns / 1ps

package shlms_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned SAMPLE_BYTES_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned FILL_W            = 11;

  // FNV-1a 64-bit offset basis; the prime is 2^40 + 0x1B3
  localparam logic [63:0] HASH_BASIS    = 64'hCBF29CE484222325;
  localparam logic [63:0] HASH_PRIME_LO = 64'h00000000000001B3;
  localparam int unsigned PRIME_SHIFT   = 40;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] fd;
    logic signed [63:0] pos;
    logic [63:0]        count;
    logic [5:0]         sample_len;
    logic [63:0]        data_word0;
    logic [63:0]        data_word1;
    logic [63:0]        data_word2;
    logic [63:0]        data_word3;
  } shlms_in_t;

  typedef struct packed {
    logic [63:0]       signature;
    logic              found;
    logic              report_unknown;
    logic              inserted;
    logic              table_full;
    logic [FILL_W-1:0] fill_count;
  } shlms_out_t;

  // Entry of the queue between hash front and table engine
  typedef struct packed {
    logic        clr;
    logic [63:0] sig;
  } shlms_qent_t;

  // One hash step: xor the operand in, multiply by the prime mod 2^64
  function automatic logic [63:0] shlms_mix(input logic [63:0] h, input logic [63:0] v);
    logic [63:0] x;
    x = h ^ v;
    return (x << PRIME_SHIFT) + 64'(x * HASH_PRIME_LO);
  endfunction

endpackage

// File: hw/rtl/signature_hash_learn_monitor_set.sv
// Top level of the call-signature learn/monitor hash set.
`timescale 1ns / 1ps
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one item per call, or a clear
// item (mode = 1). Output channel (out_valid_o/out_ready_i/out_item_o): exactly
// one result per item, in order. cfg_we_i writes learn_enable from cfg_wdata_i.
// A call item is hashed in the front end over fd, pos, count and then L sample
// bytes (L = saturated sample length), one 64-bit multiply-add step per operand.
// The table engine first reduces the signature mod TABLE_ENTRIES when that is
// not a power of two, then reads and compares each probed slot, and finally
// loads the output register. A clear item sweeps the whole memory to zero.
// A two-entry queue lets the front end hash the next item while the engine
// probes. After reset the engine clears the whole memory and in_ready_o stays
// low until that sweep ends. While the receiver stalls, the result waits in
// the output register, the queue fills, and then in_ready_o drops.

module signature_hash_learn_monitor_set #(
  parameter int unsigned TABLE_ENTRIES = shlms_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SAMPLE_BYTES  = shlms_pkg::SAMPLE_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  shlms_pkg::shlms_in_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output shlms_pkg::shlms_out_t out_item_o
);
  import shlms_pkg::*;

  logic        learn_q;
  logic        init_busy;
  logic        push, push_full;
  shlms_qent_t push_ent;
  logic        q_empty, q_pop;
  shlms_qent_t q_ent;

  // Hold the learn/monitor mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q <= 1'b1;
    end else if (cfg_we_i) begin
      learn_q <= cfg_wdata_i;
    end
  end

  shlms_hash #(
    .SAMPLE_BYTES(SAMPLE_BYTES)
  ) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_busy_i(init_busy),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .push_ent_o (push_ent),
    .push_full_i(push_full)
  );

  shlms_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ent_i(push_ent),
    .full_o    (push_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .pop_ent_o (q_ent)
  );

  shlms_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .learn_enable_i(learn_q),
    .init_busy_o   (init_busy),
    .q_valid_i     (!q_empty),
    .q_ent_i       (q_ent),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule

// File: hw/rtl/shlms_hash.sv
// Front end: accepts items, classifies them and forms the 64-bit signature.
`timescale 1ns / 1ps

module shlms_hash #(
  parameter int unsigned SAMPLE_BYTES = shlms_pkg::SAMPLE_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   init_busy_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  shlms_pkg::shlms_in_t   in_item_i,
  output logic                   push_o,
  output shlms_pkg::shlms_qent_t push_ent_o,
  input  logic                   push_full_i
);
  import shlms_pkg::*;

  localparam int unsigned DATA_W  = SAMPLE_BYTES * 8;
  localparam int unsigned BI_W    = (SAMPLE_BYTES > 1) ? $clog2(SAMPLE_BYTES) : 1;
  localparam logic [5:0]  LEN_MAX = 6'(SAMPLE_BYTES);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MIX  = 3'b010,
    F_PUSH = 3'b100
  } hash_state_e;

  hash_state_e       state_q, state_d;
  logic [63:0]       h_q, h_d;
  logic [5:0]        step_q, step_d;
  logic [5:0]        len_q, len_d;
  logic              clr_q, clr_d;
  logic [63:0]       fd_q, pos_q, cnt_q;
  logic [DATA_W-1:0] data_q;
  logic [255:0]      words;
  logic [BI_W-1:0]   bidx;
  logic [63:0]       operand;
  logic              in_accept;

  assign in_ready_o = (state_q == F_IDLE) && !init_busy_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign words      = {in_item_i.data_word3, in_item_i.data_word2,
                       in_item_i.data_word1, in_item_i.data_word0};

  // Pick the operand of this step: descriptor words, then sample bytes
  assign bidx = BI_W'(step_q - 6'd3);
  always_comb begin
    case (step_q)
      6'd0:    operand = fd_q;
      6'd1:    operand = pos_q;
      6'd2:    operand = cnt_q;
      default: operand = {56'd0, data_q[bidx*8 +: 8]};
    endcase
  end

  // Sequence accept, one mix per cycle, hand-off to the queue
  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    step_d  = step_q;
    len_d   = len_q;
    clr_d   = clr_q;
    case (state_q)
      F_IDLE: begin
        if (in_accept) begin
          if (in_item_i.mode) begin
            clr_d   = 1'b1;
            h_d     = '0;
            state_d = F_PUSH;
          end else begin
            clr_d   = 1'b0;
            h_d     = HASH_BASIS;
            step_d  = '0;
            len_d   = (in_item_i.sample_len > LEN_MAX) ? LEN_MAX : in_item_i.sample_len;
            state_d = F_MIX;
          end
        end
      end
      F_MIX: begin
        h_d = shlms_mix(h_q, operand);
        if (step_q == 6'd2 + len_q) begin
          state_d = F_PUSH;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      F_PUSH: begin
        if (!push_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      len_q   <= '0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      len_q   <= len_d;
      clr_q   <= clr_d;
    end
  end

  // Capture the item payload and the running hash
  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (in_accept) begin
      fd_q   <= {{32{in_item_i.fd[31]}}, in_item_i.fd};
      pos_q  <= in_item_i.pos;
      cnt_q  <= in_item_i.count;
      data_q <= words[DATA_W-1:0];
    end
  end

  assign push_o         = (state_q == F_PUSH);
  assign push_ent_o.clr = clr_q;
  assign push_ent_o.sig = h_q;

endmodule

// File: hw/rtl/shlms_fifo.sv
// Short queue between the hash front end and the table engine.
`timescale 1ns / 1ps

module shlms_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  shlms_pkg::shlms_qent_t push_ent_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output shlms_pkg::shlms_qent_t pop_ent_o
);
  import shlms_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  shlms_qent_t      slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == DEPTH_C);
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_ent_o = slots_q[rd_ptr_q];

  // Advance pointers and the occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_ent_i;
    end
  end

endmodule

// File: hw/rtl/shlms_table.sv
// Back end: linear-probe lookup, insert and clear of the signature table.
`timescale 1ns / 1ps
`include "signature_hash_learn_monitor_set_assert.svh"

module shlms_table #(
  parameter int unsigned TABLE_ENTRIES = shlms_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   learn_enable_i,
  output logic                   init_busy_o,
  input  logic                   q_valid_i,
  input  shlms_pkg::shlms_qent_t q_ent_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output shlms_pkg::shlms_out_t  out_item_o
);
  import shlms_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW1     = IDX_W + 1;
  localparam bit          IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [RW1-1:0]   MOD_N     = RW1'(TABLE_ENTRIES);

  typedef enum logic [6:0] {
    T_INIT = 7'b0000001,
    T_IDLE = 7'b0000010,
    T_MOD  = 7'b0000100,
    T_RD   = 7'b0001000,
    T_CMP  = 7'b0010000,
    T_CLR  = 7'b0100000,
    T_OUT  = 7'b1000000
  } table_state_e;

  table_state_e     state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] tried_q, tried_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [2:0]       modcnt_q, modcnt_d;
  logic [63:0]      sh_q, sh_d;
  logic [63:0]      sig_q, sig_d;
  logic             found_q, found_d;
  logic             report_q, report_d;
  logic             ins_q, ins_d;
  logic             full_q, full_d;
  logic             out_valid_q, out_valid_d;
  shlms_out_t       out_item_q, out_item_d;

  logic [63:0]      store_q [TABLE_ENTRIES];
  logic [63:0]      rdata_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [63:0]      mem_wdata;
  logic [RW1-1:0]   rem_v;
  logic [IDX_W-1:0] rem_next;
  logic             has_room;
  logic [IDX_W-1:0] idx_inc;

  // Reduce the signature mod the table size, eight bits a cycle, MSB first
  always_comb begin
    rem_v = {1'b0, idx_q};
    for (int k = 0; k < 8; k++) begin
      rem_v = {rem_v[IDX_W-1:0], sh_q[63-k]};
      if (rem_v >= MOD_N) begin
        rem_v = rem_v - MOD_N;
      end
    end
    rem_next = rem_v[IDX_W-1:0];
  end

  assign has_room    = (used_q < ENTRIES_C);
  assign idx_inc     = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign init_busy_o = (state_q == T_INIT);

  // Sequence the reset clear, probe, insert, clear sweep and result hand-off
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tried_d     = tried_q;
    used_d      = used_q;
    modcnt_d    = modcnt_q;
    sh_d        = sh_q;
    sig_d       = sig_q;
    found_d     = found_q;
    report_d    = report_q;
    ins_d       = ins_q;
    full_d      = full_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = sig_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    case (state_q)
      T_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (idx_q == LAST_IDX) begin
          state_d = T_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      T_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          found_d  = 1'b0;
          report_d = 1'b0;
          ins_d    = 1'b0;
          full_d   = 1'b0;
          tried_d  = '0;
          if (q_ent_i.clr) begin
            sig_d   = '0;
            idx_d   = '0;
            state_d = T_CLR;
          end else begin
            sig_d = q_ent_i.sig;
            if (q_ent_i.sig == '0) begin
              // Zero never matches a slot; it counts but is never stored
              if (!learn_enable_i) begin
                report_d = 1'b1;
              end else if (has_room) begin
                ins_d  = 1'b1;
                used_d = used_q + 1'b1;
              end else begin
                full_d = 1'b1;
              end
              state_d = T_OUT;
            end else if (IS_POW2) begin
              idx_d   = q_ent_i.sig[IDX_W-1:0];
              state_d = T_RD;
            end else begin
              idx_d    = '0;
              sh_d     = q_ent_i.sig;
              modcnt_d = '0;
              state_d  = T_MOD;
            end
          end
        end
      end
      T_MOD: begin
        idx_d    = rem_next;
        sh_d     = sh_q << 8;
        modcnt_d = modcnt_q + 3'd1;
        if (modcnt_q == 3'd7) begin
          state_d = T_RD;
        end
      end
      T_RD: begin
        mem_re  = 1'b1;
        state_d = T_CMP;
      end
      T_CMP: begin
        if (rdata_q == '0) begin
          // Empty slot ends the probe; take it when learning and the table has room
          if (!learn_enable_i) begin
            report_d = 1'b1;
          end else if (has_room) begin
            ins_d  = 1'b1;
            used_d = used_q + 1'b1;
            mem_we = 1'b1;
          end else begin
            full_d = 1'b1;
          end
          state_d = T_OUT;
        end else if (rdata_q == sig_q) begin
          found_d = 1'b1;
          state_d = T_OUT;
        end else if (tried_q == ENTRIES_C - 1'b1) begin
          // Every slot probed without an empty one
          if (!learn_enable_i) begin
            report_d = 1'b1;
          end else if (has_room) begin
            ins_d  = 1'b1;
            used_d = used_q + 1'b1;
          end else begin
            full_d = 1'b1;
          end
          state_d = T_OUT;
        end else begin
          tried_d = tried_q + 1'b1;
          idx_d   = idx_inc;
          state_d = T_RD;
        end
      end
      T_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (idx_q == LAST_IDX) begin
          used_d  = '0;
          state_d = T_OUT;
        end else begin
          idx_d = idx_inc;
        end
      end
      T_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d               = 1'b1;
          out_item_d.signature      = sig_q;
          out_item_d.found          = found_q;
          out_item_d.report_unknown = report_q;
          out_item_d.inserted       = ins_q;
          out_item_d.table_full     = full_q;
          out_item_d.fill_count     = FILL_W'(used_q);
          state_d                   = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_INIT;
      idx_q       <= '0;
      tried_q     <= '0;
      used_q      <= '0;
      modcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      tried_q     <= tried_d;
      used_q      <= used_d;
      modcnt_q    <= modcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the signature, result flags and output item
  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    sig_q      <= sig_d;
    found_q    <= found_d;
    report_q   <= report_d;
    ins_q      <= ins_d;
    full_q     <= full_d;
    out_item_q <= out_item_d;
  end

  // Signature memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_q[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SHLMS_ASSERT(a_used_bound, used_q <= ENTRIES_C)
  `SHLMS_ASSERT(a_probe_bound, (state_q == T_CMP) |-> (tried_q < ENTRIES_C))
  `SHLMS_ASSERT(a_store_nonzero, (mem_we && (state_q == T_CMP)) |-> (sig_q != '0))
  `SHLMS_ASSERT(a_clear_sweep, (q_pop_o && q_ent_i.clr) |=> (state_q == T_CLR))
  `SHLMS_ASSERT_NEVER(a_ins_full_excl, out_valid_q && out_item_q.inserted && out_item_q.table_full)

endmodule
